// ----- src/djj_pkg.sv -----
// Package for the distance joint Jacobian unit.
// It holds the fixed-point format, the store layout, the register indexes and helpers.
// It depends on nothing.
package djj_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SLOTS     = 22;
  localparam int DEPTH     = 2 * SLOTS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int NUM_RES   = 25;
  localparam int NUM_W     = 32 + FRAC_BITS + 1;

  localparam logic signed [31:0] ONE_Q    = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] THRESH_Q = ONE_Q / 1000000;
  localparam logic signed [31:0] Q_MAX    = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;
  localparam logic [63:0]        HALF_Q   = 64'd1 << (FRAC_BITS - 1);

  localparam logic [4:0] SLOT_POS  = 5'd0;
  localparam logic [4:0] SLOT_ROT  = 5'd3;
  localparam logic [4:0] SLOT_INV  = 5'd12;
  localparam logic [4:0] SLOT_MASS = 5'd21;

  localparam logic [2:0] CFG_ANCHOR_A_X = 3'd0;
  localparam logic [2:0] CFG_REST       = 3'd6;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v[65:31] == {35{v[65]}}) begin
      return v[31:0];
    end else if (!v[65]) begin
      return Q_MAX;
    end else begin
      return Q_MIN;
    end
  endfunction

  function automatic logic signed [63:0] mulq(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + $signed(HALF_Q);
    return s >>> FRAC_BITS;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic b, input logic [4:0] s);
    return b ? ADDR_W'(SLOTS) + ADDR_W'(s) : ADDR_W'(s);
  endfunction

endpackage

// ----- src/distance_joint_jacobian_unit.sv -----
// Top level of the distance joint Jacobian unit: load handling, sequencer and datapath.
// It depends on djj_pkg, djj_store, djj_sqrt and djj_div.
// A load item is taken only while the unit is idle; an item with compute_now starts a run
// that uses the bit-serial divider (up to nine quotients) and the shared
// multiplier that reads rotation and inertia words from the store, then 25 result items.
// Reset clears the sequencer and the config registers (anchors 0, rest length 1.0); the body
// store is not cleared and holds undefined words until they are loaded.
module distance_joint_jacobian_unit import djj_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               body_sel_i,
  input  logic [4:0]         slot_i,
  input  logic signed [31:0] value_i,
  input  logic               compute_now_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         result_index_o,
  output logic signed [31:0] result_value_o,
  output logic               last_result_o,
  output logic               degenerate_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_RD    = 12'b0000_0000_0010,
    ST_MUL   = 12'b0000_0000_0100,
    ST_ACC   = 12'b0000_0000_1000,
    ST_POS   = 12'b0000_0001_0000,
    ST_SEP   = 12'b0000_0010_0000,
    ST_SQRT  = 12'b0000_0100_0000,
    ST_DRD   = 12'b0000_1000_0000,
    ST_DGO   = 12'b0001_0000_0000,
    ST_DWAIT = 12'b0010_0000_0000,
    ST_OUT   = 12'b0100_0000_0000,
    ST_SPARE = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [1:0] {PH_ROT, PH_SQ, PH_CRS, PH_ANG} phase_e;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [2:0] o_q, o_d;
  logic [1:0] t_q, t_d;
  logic [3:0] d_q, d_d;
  logic [4:0] oc_q, oc_d;
  logic       degen_q, degen_d;

  logic signed [65:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] p_q [6], p_d [6];
  logic signed [31:0] ang_q [6], ang_d [6];
  logic signed [31:0] sep_q [3], sep_d [3];
  logic signed [31:0] nrm_q [3], nrm_d [3];
  logic signed [31:0] negn_q [3], negn_d [3];
  logic signed [31:0] res_q [NUM_RES], res_d [NUM_RES];
  logic signed [31:0] len_q, len_d;
  logic signed [31:0] anchor_q [6], anchor_d [6];
  logic [30:0]        rest_q, rest_d;

  logic               in_acc;
  logic [ADDR_W-1:0]  raddr;
  logic [31:0]        rdata;
  logic signed [31:0] rd_s, mul_a, mul_b, num_s, v, vn;
  logic               sqrt_start, sqrt_done, div_start, div_done, adv;
  logic [31:0]        root;
  logic [63:0]        sqrt_rad;
  logic signed [NUM_W-1:0] div_num, div_quo;
  logic signed [31:0] div_den;
  logic               ob, db;
  logic [1:0]         oi, di, ia, ib, last_t;
  logic [2:0]         ax;
  logic [4:0]         ridx;
  logic signed [65:0] tm;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_s       = $signed(rdata);

  djj_store u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && (slot_i < 5'(SLOTS))),
    .waddr_i (store_addr(body_sel_i, slot_i)),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  djj_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  djj_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    ob     = (o_q >= 3'd3);
    oi     = ob ? 2'(o_q - 3'd3) : o_q[1:0];
    db     = (d_q >= 4'd6);
    di     = (d_q < 4'd3) ? d_q[1:0] : (db ? 2'(d_q - 4'd6) : 2'(d_q - 4'd3));
    ia     = (t_q == 2'd0) ? ((oi == 2'd2) ? 2'd0 : 2'(oi + 2'd1))
                           : ((oi == 2'd0) ? 2'd2 : 2'(oi - 2'd1));
    ib     = (t_q == 2'd0) ? ((oi == 2'd0) ? 2'd2 : 2'(oi - 2'd1))
                           : ((oi == 2'd2) ? 2'd0 : 2'(oi + 2'd1));
    ax     = (ob ? 3'd3 : 3'd0) + 3'(t_q);
    last_t = (ph_q == PH_CRS) ? 2'd1 : 2'd2;
    ridx   = (d_q < 4'd6) ? 5'(d_q + 4'd10) : 5'(5'(d_q) + 5'd13);
    num_s  = (d_q < 4'd3) ? sep_q[di] : (db ? negn_q[di] : nrm_q[di]);

    raddr = '0;
    if (state_q == ST_RD) begin
      if (ph_q == PH_ROT) begin
        raddr = store_addr(ob, 5'(SLOT_ROT + 5'(oi) * 5'd3 + 5'(t_q)));
      end else begin
        raddr = store_addr(ob, 5'(SLOT_INV + 5'(t_q) * 5'd3 + 5'(oi)));
      end
    end else if (state_q == ST_ACC) begin
      raddr = store_addr(ob, 5'(SLOT_POS + 5'(oi)));
    end else if (state_q == ST_DRD) begin
      raddr = store_addr(db, SLOT_MASS);
    end

    case (ph_q)
      PH_ROT: begin
        mul_a = rd_s;
        mul_b = anchor_q[ax];
      end
      PH_SQ: begin
        mul_a = sep_q[t_q];
        mul_b = sep_q[t_q];
      end
      PH_CRS: begin
        mul_a = ob ? nrm_q[ia] : p_q[3'(ia)];
        mul_b = ob ? p_q[3'(ib) + 3'd3] : nrm_q[ib];
      end
      default: begin
        mul_a = rd_s;
        mul_b = ang_q[ax];
      end
    endcase
    tm = (ph_q == PH_SQ) ? 66'(prod_q) : 66'(mulq(prod_q));
    v  = sat32(66'(div_quo));
    vn = sat32(-66'(v));
  end

  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    o_d      = o_q;
    t_d      = t_q;
    d_d      = d_q;
    oc_d     = oc_q;
    degen_d  = degen_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    p_d      = p_q;
    ang_d    = ang_q;
    sep_d    = sep_q;
    nrm_d    = nrm_q;
    negn_d   = negn_q;
    res_d    = res_q;
    len_d    = len_q;
    anchor_d = anchor_q;
    rest_d   = rest_q;
    sqrt_start = 1'b0;
    sqrt_rad   = acc_d[63:0];
    div_start  = 1'b0;
    div_num    = NUM_W'(num_s) <<< FRAC_BITS;
    div_den    = (d_q < 4'd3) ? len_q : rd_s;
    adv        = 1'b0;

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_REST) begin
        rest_d = cfg_data_i[30:0];
      end else if (cfg_index_i < CFG_REST) begin
        anchor_d[cfg_index_i - CFG_ANCHOR_A_X] = $signed(cfg_data_i);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && compute_now_i) begin
          ph_d    = PH_ROT;
          o_d     = '0;
          t_d     = '0;
          acc_d   = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = 64'(mul_a) * 64'(mul_b);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = (ph_q == PH_CRS && t_q == 2'd1) ? acc_q - tm : acc_q + tm;
        if (t_q != last_t) begin
          t_d     = t_q + 2'd1;
          state_d = ST_RD;
        end else begin
          t_d = '0;
          case (ph_q)
            PH_ROT: begin
              state_d = ST_POS;
            end
            PH_SQ: begin
              sqrt_rad   = acc_d[63:0];
              sqrt_start = 1'b1;
              state_d    = ST_SQRT;
            end
            PH_CRS: begin
              ang_d[o_q] = sat32(acc_d);
              res_d[ob ? 5'(o_q) + 5'd7 : 5'(o_q) + 5'd4] = sat32(acc_d);
              acc_d   = '0;
              state_d = ST_RD;
              if (o_q == 3'd5) begin
                ph_d = PH_ANG;
                o_d  = '0;
              end else begin
                o_d = o_q + 3'd1;
              end
            end
            default: begin
              res_d[ob ? 5'(o_q) + 5'd19 : 5'(o_q) + 5'd16] = sat32(acc_d);
              acc_d   = '0;
              state_d = ST_RD;
              if (o_q == 3'd5) begin
                d_d     = 4'd3;
                state_d = ST_DRD;
              end else begin
                o_d = o_q + 3'd1;
              end
            end
          endcase
        end
      end
      ST_POS: begin
        p_d[o_q] = sat32(66'(rd_s) + 66'(sat32(acc_q)));
        acc_d    = '0;
        if (o_q == 3'd5) begin
          state_d = ST_SEP;
        end else begin
          o_d     = o_q + 3'd1;
          state_d = ST_RD;
        end
      end
      ST_SEP: begin
        for (int k = 0; k < 3; k++) begin
          sep_d[k] = sat32(66'(p_q[k + 3]) - 66'(p_q[k]));
        end
        ph_d    = PH_SQ;
        t_d     = '0;
        acc_d   = '0;
        state_d = ST_RD;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          len_d    = root[31] ? Q_MAX : $signed(root);
          res_d[0] = sat32(66'(len_d) - $signed({35'd0, rest_q}));
          degen_d  = !(len_d > THRESH_Q);
          if (degen_d) begin
            nrm_d    = '{ONE_Q, 32'sd0, 32'sd0};
            negn_d   = '{-ONE_Q, 32'sd0, 32'sd0};
            res_d[1] = ONE_Q;
            res_d[2] = '0;
            res_d[3] = '0;
            res_d[7] = -ONE_Q;
            res_d[8] = '0;
            res_d[9] = '0;
            ph_d     = PH_CRS;
            o_d      = '0;
            t_d      = '0;
            acc_d    = '0;
            state_d  = ST_RD;
          end else begin
            d_d     = '0;
            state_d = ST_DRD;
          end
        end
      end
      ST_DRD: begin
        state_d = ST_DGO;
      end
      ST_DGO: begin
        if (d_q >= 4'd3 && rd_s == 32'sd0) begin
          res_d[ridx] = (num_s > 0) ? Q_MAX : ((num_s < 0) ? Q_MIN : 32'sd0);
          adv = 1'b1;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          if (d_q < 4'd3) begin
            nrm_d[di]            = v;
            negn_d[di]           = vn;
            res_d[5'(d_q) + 5'd1] = v;
            res_d[5'(d_q) + 5'd7] = vn;
          end else begin
            res_d[ridx] = v;
          end
          adv = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (oc_q == 5'(NUM_RES - 1)) begin
            oc_d    = '0;
            state_d = ST_IDLE;
          end else begin
            oc_d = oc_q + 5'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (adv) begin
      if (d_q == 4'd2) begin
        ph_d    = PH_CRS;
        o_d     = '0;
        t_d     = '0;
        acc_d   = '0;
        state_d = ST_RD;
      end else if (d_q == 4'd8) begin
        oc_d    = '0;
        state_d = ST_OUT;
      end else begin
        d_d     = d_q + 4'd1;
        state_d = ST_DRD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ph_q     <= PH_ROT;
      o_q      <= '0;
      t_q      <= '0;
      d_q      <= '0;
      oc_q     <= '0;
      degen_q  <= 1'b0;
      anchor_q <= '{default: 32'sd0};
      rest_q   <= 31'(ONE_Q);
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      o_q      <= o_d;
      t_q      <= t_d;
      d_q      <= d_d;
      oc_q     <= oc_d;
      degen_q  <= degen_d;
      anchor_q <= anchor_d;
      rest_q   <= rest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    p_q    <= p_d;
    ang_q  <= ang_d;
    sep_q  <= sep_d;
    nrm_q  <= nrm_d;
    negn_q <= negn_d;
    res_q  <= res_d;
    len_q  <= len_d;
  end

  assign out_valid_o    = (state_q == ST_OUT);
  assign result_index_o = oc_q;
  assign result_value_o = res_q[oc_q];
  assign last_result_o  = (oc_q == 5'(NUM_RES - 1));
  assign degenerate_o   = degen_q;

endmodule

// ----- src/djj_store.sv -----
// Body state memory: two bodies of 22 words, one write and one registered read port.
// It depends on djj_pkg.
module djj_store import djj_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/djj_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
// It depends on djj_pkg.
module djj_sqrt import djj_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] x_q, x_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [35:0] r, trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    r      = {rem_q, x_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      x_d    = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      x_d = {x_q[61:0], 2'b00};
      if (r >= trial) begin
        rem_d  = 34'(r - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = r[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- src/djj_div.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// It depends on djj_pkg.
module djj_div import djj_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [31:0]      den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] work_q, work_d;
  logic [31:0]      rem_q, rem_d, dvs_q, dvs_d;
  logic [32:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, work_q[NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      neg_d  = num_i[NUM_W-1] ^ den_i[31];
      work_d = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      dvs_d  = den_i[31] ? 32'(-den_i) : 32'(den_i);
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = 32'(trial - {1'b0, dvs_q});
        work_d = {work_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        work_d = {work_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(work_q) : $signed(work_q);

endmodule
